// ===== rtl/escape_time_fractal_pixel_top_macros.svh =====
// ----------------------------------------------------------------------------
// Escape-time pixel engine: assertion macros
// Short forms for the clocked, reset-qualified properties of the engine.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_TOP_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_TOP_MACROS_SVH

// same-cycle implication
`define ETF_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ETF_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/etf_pkg.sv =====
// ----------------------------------------------------------------------------
// Escape-time pixel engine package
// Widths, register map, configuration type and small helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package etf_pkg;

  localparam int IMAGE_WIDTH = 1024;

  localparam int COORD_W   = 10;
  localparam int IN_W      = 32;          // Q8.24 input and constant width
  localparam int IDX_W     = 20;
  localparam int CNT_W     = 12;
  localparam int VAL_W     = 32;
  localparam int COL_W     = 24;
  localparam int GAIN_W    = 4;

  localparam int FRAC_BITS = 24;
  localparam int MAG_BITS  = 28;          // |re|, |im| >= 16 at scale 2^24
  localparam int ESC_BIT   = 56;          // re^2 + im^2 >= 256 at scale 2^48
  localparam int Z_W       = 38;          // running re, im (Q14.24 plus margin)
  localparam int MUL_W     = MAG_BITS + 1;
  localparam int PROD_W    = 2 * MUL_W;

  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  // register indexes
  localparam logic [2:0] REG_C_RE   = 3'd0;
  localparam logic [2:0] REG_C_IM   = 3'd1;
  localparam logic [2:0] REG_MAX_IT = 3'd2;
  localparam logic [2:0] REG_MODE   = 3'd3;
  localparam logic [2:0] REG_GAIN   = 3'd4;
  localparam logic [2:0] REG_COLOUR = 3'd5;

  typedef struct packed {
    logic signed [IN_W-1:0]  c_re;
    logic signed [IN_W-1:0]  c_im;
    logic [CNT_W-1:0]        max_iters;
    logic                    formula_mode;
    logic [GAIN_W-1:0]       imag_gain;
    logic [COL_W-1:0]        colour_scale;
  } cfg_t;

  function automatic logic signed [Z_W-1:0] sext_z(input logic signed [IN_W-1:0] v);
    return {{(Z_W-IN_W){v[IN_W-1]}}, v};
  endfunction

  // true while |v| < 2^MAG_BITS
  function automatic logic in_range(input logic signed [Z_W-1:0] v);
    logic [Z_W-MAG_BITS-1:0] hi;
    hi = v[Z_W-1:MAG_BITS];
    return (hi == '0) || ((hi == '1) && (v[MAG_BITS-1:0] != '0));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/etf_cfg.sv =====
// ----------------------------------------------------------------------------
// Escape-time pixel engine: register file
// APB-style write and read of the six configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module etf_cfg (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [etf_pkg::ADDR_W-1:0]    paddr,
  input  wire [etf_pkg::DATA_W-1:0]    pwdata,
  output logic [etf_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output etf_pkg::cfg_t                cfg
);

  etf_pkg::cfg_t cfg_r, cfg_nxt;
  logic [2:0]    idx;
  logic          wr;

  assign idx    = paddr[etf_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        etf_pkg::REG_C_RE:   cfg_nxt.c_re         = pwdata;
        etf_pkg::REG_C_IM:   cfg_nxt.c_im         = pwdata;
        etf_pkg::REG_MAX_IT: cfg_nxt.max_iters    = pwdata[etf_pkg::CNT_W-1:0];
        etf_pkg::REG_MODE:   cfg_nxt.formula_mode = pwdata[0];
        etf_pkg::REG_GAIN:   cfg_nxt.imag_gain    = pwdata[etf_pkg::GAIN_W-1:0];
        etf_pkg::REG_COLOUR: cfg_nxt.colour_scale = pwdata[etf_pkg::COL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      etf_pkg::REG_C_RE:   prdata = cfg_r.c_re;
      etf_pkg::REG_C_IM:   prdata = cfg_r.c_im;
      etf_pkg::REG_MAX_IT: prdata = {{(etf_pkg::DATA_W-etf_pkg::CNT_W){1'b0}}, cfg_r.max_iters};
      etf_pkg::REG_MODE:   prdata = {{(etf_pkg::DATA_W-1){1'b0}}, cfg_r.formula_mode};
      etf_pkg::REG_GAIN:   prdata = {{(etf_pkg::DATA_W-etf_pkg::GAIN_W){1'b0}}, cfg_r.imag_gain};
      etf_pkg::REG_COLOUR: prdata = {{(etf_pkg::DATA_W-etf_pkg::COL_W){1'b0}},
                                     cfg_r.colour_scale};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_re         <= '0;
      cfg_r.c_im         <= '0;
      cfg_r.max_iters    <= etf_pkg::CNT_W'(50);
      cfg_r.formula_mode <= 1'b1;
      cfg_r.imag_gain    <= etf_pkg::GAIN_W'(2);
      cfg_r.colour_scale <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/etf_mul.sv =====
// ----------------------------------------------------------------------------
// Escape-time pixel engine: shared multiplier
// Signed multiplier with a registered product, one product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module etf_mul (
  input  wire                                 clk,
  input  wire signed [etf_pkg::MUL_W-1:0]     a,
  input  wire signed [etf_pkg::MUL_W-1:0]     b,
  output logic signed [etf_pkg::PROD_W-1:0]   p
);

  logic signed [etf_pkg::PROD_W-1:0] p_r;

  assign p = p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

`default_nettype wire

// ===== rtl/etf_core.sv =====
// ----------------------------------------------------------------------------
// Escape-time pixel engine: iteration sequencer
// Steps one pixel through the iteration with the shared multiplier and
// holds the finished word in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "escape_time_fractal_pixel_top_macros.svh"

module etf_core (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire etf_pkg::cfg_t                   cfg,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire [etf_pkg::COORD_W-1:0]           pixel_x,
  input  wire [etf_pkg::COORD_W-1:0]           pixel_y,
  input  wire signed [etf_pkg::IN_W-1:0]       start_re,
  input  wire signed [etf_pkg::IN_W-1:0]       start_im,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [etf_pkg::IDX_W-1:0]            pixel_index,
  output logic [etf_pkg::CNT_W-1:0]            iteration_count,
  output logic [etf_pkg::VAL_W-1:0]            pixel_value,
  output logic signed [etf_pkg::MUL_W-1:0]     mul_a,
  output logic signed [etf_pkg::MUL_W-1:0]     mul_b,
  input  wire signed [etf_pkg::PROD_W-1:0]     mul_p
);

  localparam int Z_W    = etf_pkg::Z_W;
  localparam int MUL_W  = etf_pkg::MUL_W;
  localparam int PROD_W = etf_pkg::PROD_W;
  localparam int CNT_W  = etf_pkg::CNT_W;
  localparam int IDX_W  = etf_pkg::IDX_W;
  localparam int XK_W   = PROD_W + etf_pkg::GAIN_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;   // magnitude test, issue re*re
  localparam logic [2:0] S_SQI  = 3'd2;   // issue im*im
  localparam logic [2:0] S_XMUL = 3'd3;   // square-sum test, issue re*im
  localparam logic [2:0] S_UPD  = 3'd4;   // form the new z
  localparam logic [2:0] S_COL  = 3'd5;   // issue colour*count
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]               state_r, state_nxt;
  logic signed [Z_W-1:0]    re_r, re_nxt, im_r, im_nxt;
  logic [CNT_W-1:0]         n_r, n_nxt, max_n_r, max_n_nxt;
  logic                     esc_r, esc_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic signed [PROD_W-1:0] re2_r, re2_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]         out_idx_r, out_idx_nxt;
  logic [CNT_W-1:0]         out_cnt_r, out_cnt_nxt;
  logic [etf_pkg::VAL_W-1:0] out_val_r, out_val_nxt;

  logic [PROD_W-1:0]        sq_sum;
  logic signed [PROD_W-1:0] rsq, isq;
  logic signed [XK_W-1:0]   xk, xk_sh;
  logic signed [Z_W-1:0]    re_upd, im_upd;

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign pixel_index     = out_idx_r;
  assign iteration_count = out_cnt_r;
  assign pixel_value     = out_val_r;

  // squares are non-negative and below 2^56 each, so the sum cannot wrap
  assign sq_sum = $unsigned(re2_r) + $unsigned(mul_p);

  assign rsq   = re2_r >>> etf_pkg::FRAC_BITS;
  assign isq   = mul_p >>> etf_pkg::FRAC_BITS;
  assign xk    = mul_p * $signed({1'b0, cfg.imag_gain});
  assign xk_sh = xk >>> (etf_pkg::FRAC_BITS + 1);

  always_comb begin
    re_upd = cfg.formula_mode ? (rsq[Z_W-1:0] - isq[Z_W-1:0])
                              : (rsq[Z_W-1:0] + isq[Z_W-1:0]);
    re_upd = re_upd + etf_pkg::sext_z(cfg.c_re);
    im_upd = xk_sh[Z_W-1:0] + etf_pkg::sext_z(cfg.c_im);
  end

  always_comb begin
    state_nxt     = state_r;
    re_nxt        = re_r;
    im_nxt        = im_r;
    n_nxt         = n_r;
    max_n_nxt     = max_n_r;
    esc_nxt       = esc_r;
    idx_nxt       = idx_r;
    re2_nxt       = re2_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_cnt_nxt   = out_cnt_r;
    out_val_nxt   = out_val_r;
    mul_a         = re_r[MUL_W-1:0];
    mul_b         = re_r[MUL_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          re_nxt    = etf_pkg::sext_z(start_re);
          im_nxt    = etf_pkg::sext_z(start_im);
          n_nxt     = '0;
          esc_nxt   = 1'b0;
          max_n_nxt = cfg.max_iters;
          idx_nxt   = IDX_W'(32'(pixel_x) + 32'(pixel_y) * etf_pkg::IMAGE_WIDTH);
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (!etf_pkg::in_range(re_r) || !etf_pkg::in_range(im_r)) begin
          esc_nxt   = 1'b1;
          state_nxt = S_COL;
        end else begin
          state_nxt = S_SQI;
        end
      end
      S_SQI: begin
        re2_nxt   = mul_p;
        mul_a     = im_r[MUL_W-1:0];
        mul_b     = im_r[MUL_W-1:0];
        state_nxt = S_XMUL;
      end
      S_XMUL: begin
        mul_a = re_r[MUL_W-1:0];
        mul_b = im_r[MUL_W-1:0];
        if (sq_sum[PROD_W-1:etf_pkg::ESC_BIT] != '0) begin
          esc_nxt   = 1'b1;
          state_nxt = S_COL;
        end else if (n_r == max_n_r) begin
          state_nxt = S_COL;
        end else begin
          re2_nxt   = {{(PROD_W-Z_W){re_upd[Z_W-1]}}, re_upd};
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        // re2_r now holds the new real part, mul_p the cross product
        re_nxt    = re2_r[Z_W-1:0];
        im_nxt    = im_upd;
        n_nxt     = n_r + CNT_W'(1);
        state_nxt = S_CHK;
      end
      S_COL, S_EMIT: begin
        mul_a = MUL_W'(cfg.colour_scale);
        mul_b = MUL_W'(n_r);
        if (state_r == S_COL) begin
          state_nxt = S_EMIT;
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_r;
          out_cnt_nxt   = n_r;
          out_val_nxt   = esc_r ? mul_p[etf_pkg::VAL_W-1:0] : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    re_r      <= re_nxt;
    im_r      <= im_nxt;
    n_r       <= n_nxt;
    max_n_r   <= max_n_nxt;
    esc_r     <= esc_nxt;
    idx_r     <= idx_nxt;
    re2_r     <= re2_nxt;
    out_idx_r <= out_idx_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_val_r <= out_val_nxt;
  end

  `ETF_ASSERT_NXT(a_accept_start, clk, rst_n, (state_r == S_IDLE) && in_valid, (state_r == S_CHK) && (n_r == '0), "accepted word did not start at count zero")
  `ETF_ASSERT_NXT(a_upd_step, clk, rst_n, state_r == S_UPD, (state_r == S_CHK) && (n_r == $past(n_r) + CNT_W'(1)), "update did not advance the count by one")
  `ETF_ASSERT_IMP(a_xmul_range, clk, rst_n, state_r == S_XMUL, etf_pkg::in_range(re_r) && etf_pkg::in_range(im_r), "squares taken of an escaped point")
  `ETF_ASSERT_IMP(a_limit_only, clk, rst_n, (state_r == S_EMIT) && !esc_r, n_r == max_n_r, "non-escaped pixel below the iteration limit")

endmodule

`default_nettype wire

// ===== rtl/escape_time_fractal_pixel_top.sv =====
// Each iteration steps through S_CHK, S_SQI, S_XMUL and S_UPD until the pixel
// escapes or reaches the limit; S_COL and S_EMIT then colour it and load the
// output word, waiting in S_EMIT while the last word is untaken. A new pixel
// is taken only in S_IDLE; one shared 29x29 multiplier takes re^2, im^2, re*im.
// Reset (rst_n low, synchronous) idles the sequencer, empties the output
// register and loads the register defaults.
// ----------------------------------------------------------------------------
// Escape-time pixel engine
// Julia-style escape-time iteration of one pixel per input word.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_time_fractal_pixel_top (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // pixel_x[9:0], pixel_y[19:10], start_re[51:20], start_im[83:52], zero pad
  input  wire [87:0]                   in_tdata,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // pixel_index[19:0], iteration_count[31:20], pixel_value[63:32]
  output logic [63:0]                  out_tdata,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire [etf_pkg::ADDR_W-1:0]    cfg_paddr,
  input  wire [etf_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [etf_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  etf_pkg::cfg_t                          cfg;
  logic signed [etf_pkg::MUL_W-1:0]       mul_a, mul_b;
  logic signed [etf_pkg::PROD_W-1:0]      mul_p;
  logic [etf_pkg::IDX_W-1:0]              pixel_index;
  logic [etf_pkg::CNT_W-1:0]              iteration_count;
  logic [etf_pkg::VAL_W-1:0]              pixel_value;

  etf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  etf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  etf_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .pixel_x         (in_tdata[9:0]),
    .pixel_y         (in_tdata[19:10]),
    .start_re        (in_tdata[51:20]),
    .start_im        (in_tdata[83:52]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .pixel_index     (pixel_index),
    .iteration_count (iteration_count),
    .pixel_value     (pixel_value),
    .mul_a           (mul_a),
    .mul_b           (mul_b),
    .mul_p           (mul_p)
  );

  assign out_tdata = {pixel_value, iteration_count, pixel_index};

endmodule

`default_nettype wire
